[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_BITS  = 32;
    localparam int PRIO_BITS   = 8;
    localparam int TOL_W       = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DIFF_W      = VALUE_BITS + 1;
    localparam int CMP_W       = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);
    localparam logic signed [PRIO_BITS-1:0] PRIO_NONE = PRIO_BITS'(7);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic                          valid;
        logic signed [VALUE_BITS-1:0]  value;
        logic signed [PRIO_BITS-1:0]   prio;
    } slot_t;

    typedef struct packed {
        logic push;
        logic pop;
    } spq_ctrl_t;

endpackage

[rtl/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue
// Timing: push, pop and no-op results are registered in the cycle after acceptance;
//   a find first registers the match flags and the find state, then its result.
// Throughput: one push or pop per cycle while the result register is free or
//   draining; a find holds off the input while the first matching cell is selected.
// Reset: queue empty, output idle, match tolerance back to 7; slot payloads
//   are left as they are and never read while their cell is invalid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue
    import spq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [TOL_W-1:0]             cfg_wr_data,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic signed [VALUE_BITS-1:0] entry_value,
    input  logic signed [PRIO_BITS-1:0]  entry_priority,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic signed [VALUE_BITS-1:0] out_value,
    output logic signed [PRIO_BITS-1:0]  out_priority,
    output logic [CNT_W-1:0]             occupancy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIND = 1'b1;

    logic                         state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [TOL_W-1:0]             tol_reg;
    logic [QUEUE_DEPTH-1:0]       match_reg, match_next;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   status_reg, status_next;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic signed [PRIO_BITS-1:0]  prio_reg, prio_next;
    logic [CNT_W-1:0]             occ_reg, occ_next;

    logic                         in_fire;
    spq_ctrl_t                    ctrl;

    slot_t                        cell_slot [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       cell_le;
    logic [QUEUE_DEPTH-1:0]       cell_match;
    logic [QUEUE_DEPTH-1:0]       cell_valid;
    logic [QUEUE_DEPTH-1:0]       fill_mask;

    logic [QUEUE_DEPTH-1:0]       first_hit;
    logic signed [VALUE_BITS-1:0] hit_value;
    logic signed [PRIO_BITS-1:0]  hit_prio;

    slot_t                        head_slot;
    slot_t                        tail_slot;

    // New transaction only when idle and the result register is free or draining.
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // Chain ends: an always-valid head that a new key goes behind, an empty tail.
    assign head_slot = '{valid: 1'b1, value: '0, prio: '0};
    assign tail_slot = '{valid: 1'b0, value: '0, prio: '0};

    // Broadcast push/pop to every cell; a push on a full queue is dropped.
    always_comb
    begin
        ctrl.push = in_fire && (opcode == OP_PUSH) && (count_reg < CNT_W'(QUEUE_DEPTH));
        ctrl.pop  = in_fire && (opcode == OP_POP) && (count_reg != '0);
    end

    // Sorted chain: cell 0 is the queue front.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        slot_t left_slot;
        slot_t right_slot;
        logic  left_le;

        if (i == 0)
        begin : g_head
            assign left_slot = head_slot;
            assign left_le   = 1'b1;
        end
        else
        begin : g_mid
            assign left_slot = cell_slot[i-1];
            assign left_le   = cell_le[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_slot = tail_slot;
        end
        else
        begin : g_body
            assign right_slot = cell_slot[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key_value  (entry_value),
            .key_prio   (entry_priority),
            .tolerance  (tol_reg),
            .left_slot  (left_slot),
            .left_le    (left_le),
            .right_slot (right_slot),
            .slot       (cell_slot[i]),
            .le         (cell_le[i]),
            .match      (cell_match[i])
        );

        assign cell_valid[i] = cell_slot[i].valid;
        assign fill_mask[i]  = (CNT_W'(i) < count_reg);
    end

    // Pick the front-most matching cell from the flags captured at acceptance.
    assign first_hit = match_reg & (~match_reg + QUEUE_DEPTH'(1));

    always_comb
    begin
        hit_value = '0;
        hit_prio  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit_value = hit_value | ({VALUE_BITS{first_hit[i]}} & cell_slot[i].value);
            hit_prio  = hit_prio | ({PRIO_BITS{first_hit[i]}} & cell_slot[i].prio);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        value_next     = value_reg;
        prio_next      = prio_reg;
        occ_next       = occ_reg;

        if (state_reg == S_FIND)
        begin
            // Find state: deliver the selected entry or a miss.
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
            occ_next       = count_reg;
            if (match_reg != '0)
            begin
                status_next = ST_OK;
                value_next  = hit_value;
                prio_next   = hit_prio;
            end
            else
            begin
                status_next = ST_NOMATCH;
                value_next  = '0;
                prio_next   = PRIO_NONE;
            end
        end
        else if (in_fire)
        begin
            value_next = '0;
            prio_next  = PRIO_NONE;
            case (opcode)
                OP_PUSH:
                begin
                    out_valid_next = 1'b1;
                    if (ctrl.push)
                    begin
                        status_next = ST_OK;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                OP_POP:
                begin
                    out_valid_next = 1'b1;
                    if (ctrl.pop)
                    begin
                        status_next = ST_OK;
                        value_next  = cell_slot[0].value;
                        prio_next   = cell_slot[0].prio;
                        count_next  = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                OP_FIND:
                begin
                    // Hold the result until the flags are registered.
                    match_next = cell_match;
                    state_next = S_FIND;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                end
            endcase
            occ_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                tol_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg  <= match_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        prio_reg   <= prio_next;
        occ_reg    <= occ_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = value_reg;
    assign out_priority = prio_reg;
    assign occupancy    = occ_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count exceeds depth")
    `ASSERT_ALWAYS(a_valid_prefix, cell_valid == fill_mask, "cell valid bits disagree with count")
    `ASSERT_ALWAYS(a_find_slot_free, (state_reg != S_FIND) || !out_valid_reg, "find result blocked")
    `ASSERT_NEXT(a_find_enters, in_fire && (opcode == OP_FIND), state_reg == S_FIND, "find lost")
    `ASSERT_NEXT(a_find_delivers, state_reg == S_FIND, out_valid_reg && (state_reg == S_IDLE), "find result missing")

endmodule

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on an insert
// ahead of it, shifts left on a pop, and flags a find match.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  spq_ctrl_t                    ctrl,
    input  logic signed [VALUE_BITS-1:0] key_value,
    input  logic signed [PRIO_BITS-1:0]  key_prio,
    input  logic [TOL_W-1:0]             tolerance,
    input  slot_t                        left_slot,
    input  logic                         left_le,
    input  slot_t                        right_slot,
    output slot_t                        slot,
    output logic                         le,
    output logic                         match
);

    logic                         valid_reg, valid_next;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic signed [PRIO_BITS-1:0]  prio_reg, prio_next;

    logic signed [DIFF_W-1:0] diff;
    logic [CMP_W-1:0]         mag;

    assign slot = '{valid: valid_reg, value: value_reg, prio: prio_reg};

    // Entry stays ahead of a new key of equal or higher priority number.
    assign le = valid_reg && (prio_reg <= key_prio);

    always_comb
    begin
        diff  = {value_reg[VALUE_BITS-1], value_reg} - {key_value[VALUE_BITS-1], key_value};
        mag   = CMP_W'(diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff));
        match = valid_reg && (prio_reg == key_prio) && (mag < CMP_W'(tolerance));
    end

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.push && !le)
        begin
            valid_next = valid_reg | left_slot.valid;
            if (left_le)
            begin
                value_next = key_value;
                prio_next  = key_prio;
            end
            else
            begin
                value_next = left_slot.value;
                prio_next  = left_slot.prio;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = right_slot.valid;
            value_next = right_slot.value;
            prio_next  = right_slot.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule
